// File: src/rgb_to_hsv_converter_assert.svh
// Assertion macros for the RGB to HSV converter.
// Used by the top level; needs no other file.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define RHC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter: check failed");

// Condition implies consequence in the next cycle.
`define RHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter: check failed");

`endif

// File: src/rhc_pkg.sv
// Shared constants for the RGB to HSV converter.
// No dependencies.
package rhc_pkg;
  localparam int unsigned ChannelBitsDefault = 8;
  localparam int unsigned HueBitsDefault     = 8;
  localparam int unsigned QueueDepth         = 2;
endpackage

// File: src/rgb_to_hsv_converter.sv
// Converts one RGBA pixel per clock to HSV plus alpha. A pixel accepted on the input appears
// on the output after passing the queue, the input register of the divider pipeline and the
// bit-per-stage divider stages, whose last stage is the output register. With the output
// ready, one pixel is taken and one delivered
// every clock. Depends on rhc_pkg, rhc_front, rhc_fifo, rhc_back and the assertion macro header.
`include "rgb_to_hsv_converter_assert.svh"
module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::ChannelBitsDefault,
  parameter int unsigned HUE_BITS     = rhc_pkg::HueBitsDefault,
  localparam int unsigned InW  = ((4*CHANNEL_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((HUE_BITS + 3*CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // red, green, blue, alpha_in
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // hue, saturation, value, alpha_out
);
  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned EW = 5*CB + 7;

  logic [CB+2:0] f_num, f_turn;
  logic [CB-1:0] f_delta, f_max;
  logic          f_gray, q_full, q_valid, pop, push;
  logic [EW-1:0] q_wdata, q_rdata;
  logic [HUE_BITS-1:0] hue;
  logic [CB-1:0] sat, val, alpha;

  rhc_front #(.CB(CB)) u_front (
    .red_i(s_axis_tdata[CB-1:0]),
    .green_i(s_axis_tdata[2*CB-1:CB]),
    .blue_i(s_axis_tdata[3*CB-1:2*CB]),
    .hue_num_o(f_num), .turn_o(f_turn), .delta_o(f_delta), .max_o(f_max), .gray_o(f_gray)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;
  assign q_wdata = {f_gray, s_axis_tdata[4*CB-1:3*CB], f_max, f_delta, f_turn, f_num};

  rhc_fifo #(.W(EW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(q_wdata), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .rdata_o(q_rdata)
  );

  rhc_back #(.CB(CB), .HB(HUE_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_pop_o(pop),
    .hue_num_i(q_rdata[CB+2:0]),
    .turn_i(q_rdata[2*CB+5:CB+3]),
    .delta_i(q_rdata[3*CB+5:2*CB+6]),
    .max_i(q_rdata[4*CB+5:3*CB+6]),
    .alpha_i(q_rdata[5*CB+5:4*CB+6]),
    .gray_i(q_rdata[5*CB+6]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .hue_o(hue), .sat_o(sat), .value_o(val), .alpha_o(alpha)
  );

  assign m_axis_tdata = OutW'({alpha, val, sat, hue});

  `RHC_ASSERT_NOW(a_gray_hue, clk_i, rst_ni, m_axis_tvalid && sat == '0, hue == '0)
  `RHC_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

// File: src/rhc_front.sv
// Front end: finds max, min and delta, picks the hue sector and forms the hue numerator.
// Uses rhc_pkg defaults.
module rhc_front #(
  parameter int unsigned CB = rhc_pkg::ChannelBitsDefault
) (
  input  logic [CB-1:0] red_i,
  input  logic [CB-1:0] green_i,
  input  logic [CB-1:0] blue_i,
  output logic [CB+2:0] hue_num_o,
  output logic [CB+2:0] turn_o,
  output logic [CB-1:0] delta_o,
  output logic [CB-1:0] max_o,
  output logic          gray_o
);
  logic [CB-1:0] mx, mn;
  logic signed [CB+3:0] num, dl, rs, gs, bs, tn;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta_o = mx - mn;
    dl = signed'({4'b0, delta_o});
    rs = signed'({4'b0, red_i});
    gs = signed'({4'b0, green_i});
    bs = signed'({4'b0, blue_i});
    tn = (dl <<< 2) + (dl <<< 1);
    priority if (mx == red_i) begin
      num = gs - bs;
    end else if (mx == green_i) begin
      num = (dl <<< 1) + bs - rs;
    end else begin
      num = (dl <<< 2) + rs - gs;
    end
    if (num < 0) num = num + tn;
    hue_num_o = num[CB+2:0];
    turn_o    = tn[CB+2:0];
    max_o     = mx;
    gray_o    = (delta_o == '0);
  end
endmodule

// File: src/rhc_fifo.sv
// Short queue between the front end and the divider pipeline.
// Uses rhc_pkg for its depth.
module rhc_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] rdata_o
);
  logic [W-1:0] mem_q [rhc_pkg::QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// File: src/rhc_back.sv
// Back end: pipelined restoring dividers for hue and saturation, one quotient bit per stage.
// Uses rhc_pkg defaults; the last stage is the output register.
module rhc_back #(
  parameter int unsigned CB = rhc_pkg::ChannelBitsDefault,
  parameter int unsigned HB = rhc_pkg::HueBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_pop_o,
  input  logic [CB+2:0] hue_num_i,
  input  logic [CB+2:0] turn_i,
  input  logic [CB-1:0] delta_i,
  input  logic [CB-1:0] max_i,
  input  logic [CB-1:0] alpha_i,
  input  logic          gray_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [HB-1:0] hue_o,
  output logic [CB-1:0] sat_o,
  output logic [CB-1:0] value_o,
  output logic [CB-1:0] alpha_o
);
  localparam int unsigned NS = (HB > CB) ? HB : CB;

  logic          vld_q   [NS+1];
  logic [CB+2:0] hrem_q  [NS+1];
  logic [CB+2:0] turn_q  [NS+1];
  logic [HB-1:0] hq_q    [NS+1];
  logic [CB-1:0] srem_q  [NS+1];
  logic [CB-1:0] slow_q  [NS+1];
  logic [CB-1:0] sq_q    [NS+1];
  logic [CB-1:0] max_q   [NS+1];
  logic [CB-1:0] alpha_q [NS+1];
  logic          gray_q  [NS+1];
  logic          adv;
  logic [2*CB-1:0] prod;

  assign adv      = !vld_q[NS] || out_ready_i;
  assign in_pop_o = adv && in_valid_i;
  assign prod     = ({{CB{1'b0}}, delta_i} << CB) - {{CB{1'b0}}, delta_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hrem_q[0]  <= hue_num_i;
      turn_q[0]  <= turn_i;
      hq_q[0]    <= '0;
      srem_q[0]  <= prod[2*CB-1:CB];
      slow_q[0]  <= prod[CB-1:0];
      sq_q[0]    <= '0;
      max_q[0]   <= max_i;
      alpha_q[0] <= alpha_i;
      gray_q[0]  <= gray_i;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [CB+3:0] h2;
    logic [CB:0]   s2;
    logic          hbit, sbit;

    always_comb begin
      h2   = {hrem_q[k], 1'b0};
      hbit = (h2 >= {1'b0, turn_q[k]});
      s2   = {srem_q[k], slow_q[k][CB-1]};
      sbit = (s2 >= {1'b0, max_q[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        turn_q[k+1]  <= turn_q[k];
        max_q[k+1]   <= max_q[k];
        alpha_q[k+1] <= alpha_q[k];
        gray_q[k+1]  <= gray_q[k];
        if (k < HB) begin
          hrem_q[k+1] <= hbit ? (h2[CB+2:0] - turn_q[k]) : h2[CB+2:0];
          hq_q[k+1]   <= {hq_q[k][HB-2:0], hbit};
        end else begin
          hrem_q[k+1] <= hrem_q[k];
          hq_q[k+1]   <= hq_q[k];
        end
        if (k < CB) begin
          srem_q[k+1] <= sbit ? (s2[CB-1:0] - max_q[k]) : s2[CB-1:0];
          slow_q[k+1] <= {slow_q[k][CB-2:0], 1'b0};
          sq_q[k+1]   <= {sq_q[k][CB-2:0], sbit};
        end else begin
          srem_q[k+1] <= srem_q[k];
          slow_q[k+1] <= slow_q[k];
          sq_q[k+1]   <= sq_q[k];
        end
      end
    end
  end

  assign out_valid_o = vld_q[NS];
  assign hue_o       = gray_q[NS] ? '0 : hq_q[NS];
  assign sat_o       = gray_q[NS] ? '0 : sq_q[NS];
  assign value_o     = max_q[NS];
  assign alpha_o     = alpha_q[NS];
endmodule

// File: test/tb_rgb_to_hsv_converter.sv
// Testbench for rgb_to_hsv_converter: directed pixels from a table, then random pixels, with
// random gaps on both sides; each result is checked against the table's HSV where the row
// gives one, else a behavioral HSV calculation. Depends on rhc_pkg and the converter RTL.
`timescale 1ns / 1ps
module tb_rgb_to_hsv_converter;
  localparam int unsigned ChanBits = rhc_pkg::ChannelBitsDefault;
  localparam int unsigned HueBits  = rhc_pkg::HueBitsDefault;
  localparam int unsigned InW      = ((4*ChanBits + 7) / 8) * 8;
  localparam int unsigned OutW     = ((HueBits + 3*ChanBits + 7) / 8) * 8;
  localparam int unsigned NumRandom = 950;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_rgba_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] value;
    logic [7:0] sat;
    logic [7:0] hue;
  } pixel_hsva_t;

  typedef struct {
    pixel_rgba_t px;
    logic        known;
    pixel_hsva_t hsva;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  pixel_hsva_t hsva_queue[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  rgb_to_hsv_converter uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic pixel_hsva_t rgb_to_hsva(pixel_rgba_t px);
    pixel_hsva_t res;
    int mx, mn, dl, num;
    mx = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx) mx = px.blue;
    mn = px.red;
    if (px.green < mn) mn = px.green;
    if (px.blue < mn) mn = px.blue;
    dl = mx - mn;
    res = '0;
    res.value = mx[7:0];
    res.alpha = px.alpha;
    if (dl != 0) begin
      if (mx == px.red) begin
        num = int'(px.green) - int'(px.blue);
      end else if (mx == px.green) begin
        num = 2 * dl + int'(px.blue) - int'(px.red);
      end else begin
        num = 4 * dl + int'(px.red) - int'(px.green);
      end
      if (num < 0) num += 6 * dl;
      num = (num << HueBits) / (6 * dl);
      if (num > (1 << HueBits) - 1) num = (1 << HueBits) - 1;
      res.hue = num[7:0];
      res.sat = 8'((dl * ((1 << ChanBits) - 1)) / mx);
    end
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_pixel(pixel_rgba_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    hsva_queue.push_back(rgb_to_hsva(px));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  always @(posedge clk_i) begin
    pixel_hsva_t got, want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL rgb_to_hsv_converter");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (hsva_queue.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        want = hsva_queue.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, got.hue);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $error("saturation: expected %0d, got %0d", want.sat, got.sat);
          errors++;
        end
        if (got.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, got.value);
          errors++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha_out: expected %0d, got %0d", want.alpha, got.alpha);
          errors++;
        end
      end
    end
    if (!rst_ni || stim_done && $urandom_range(0, 1) == 0) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= ~m_axis_tready;
    end
  end

  table_row_t stim_table[] = '{
    '{'{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'h00, 8'h00}},
    '{'{8'h5A, 8'h80, 8'h80, 8'h80}, 1'b1, '{8'h5A, 8'h80, 8'h00, 8'h00}},
    '{'{8'hA5, 8'h00, 8'h00, 8'hFF}, 1'b1, '{8'hA5, 8'hFF, 8'hFF, 8'h00}},
    '{'{8'h00, 8'h00, 8'hFF, 8'h00}, 1'b1, '{8'h00, 8'hFF, 8'hFF, 8'h55}},
    '{'{8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hAA}},
    '{'{8'h11, 8'h00, 8'hFF, 8'hFF}, 1'b0, '0},
    '{'{8'h22, 8'hFF, 8'hFF, 8'h00}, 1'b0, '0},
    '{'{8'h33, 8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
    '{'{8'h44, 8'h01, 8'h00, 8'hFF}, 1'b0, '0},
    '{'{8'h55, 8'h00, 8'h01, 8'hFF}, 1'b0, '0},
    '{'{8'h66, 8'h00, 8'hFF, 8'hFE}, 1'b0, '0},
    '{'{8'h77, 8'hFE, 8'h00, 8'hFF}, 1'b0, '0},
    '{'{8'h88, 8'hFF, 8'h00, 8'hFE}, 1'b0, '0},
    '{'{8'h99, 8'h00, 8'h00, 8'h01}, 1'b0, '0},
    '{'{8'hAA, 8'h01, 8'h01, 8'h00}, 1'b0, '0},
    '{'{8'hBB, 8'h80, 8'h40, 8'hC0}, 1'b0, '0},
    '{'{8'hCC, 8'h10, 8'hF0, 8'h70}, 1'b0, '0},
    '{'{8'hDD, 8'hF0, 8'h10, 8'h70}, 1'b0, '0}
  };

  initial begin
    pixel_rgba_t px;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stim_table[i]) begin
      send_pixel(stim_table[i].px);
      if (stim_table[i].known) begin
        void'(hsva_queue.pop_back());
        hsva_queue.push_back(stim_table[i].hsva);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (hsva_queue.size() != 0) @(posedge clk_i);
    for (int n = 0; n < NumRandom; n++) begin
      px = $urandom;
      case ($urandom_range(0, 5))
        0: px.green = px.red;
        1: px.blue = px.green;
        2: begin
          px.green = px.red;
          px.blue = px.red;
        end
        default: ;
      endcase
      send_pixel(px);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (hsva_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && hsva_queue.size() == 0) begin
      $display("PASS rgb_to_hsv_converter");
    end else begin
      $display("FAIL rgb_to_hsv_converter");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/rhc_pkg.sv
src/rhc_front.sv
src/rhc_fifo.sv
src/rhc_back.sv
src/rgb_to_hsv_converter.sv
test/tb_rgb_to_hsv_converter.sv
